>>> design/msiva_pkg.sv
// Package for the MSI vector slot allocator.
// Holds mode and status codes, the slot entry layout, the config bundle and the sequencer states.
// No dependencies.
package msiva_pkg;

    localparam logic [2:0] MODE_ALLOC_RUN   = 3'd0;
    localparam logic [2:0] MODE_RELEASE_RUN = 3'd1;
    localparam logic [2:0] MODE_ALLOC_ONE   = 3'd2;
    localparam logic [2:0] MODE_RELEASE_ONE = 3'd3;
    localparam logic [2:0] MODE_LOOKUP      = 3'd4;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_NOT_READY = 3'd1;
    localparam logic [2:0] STAT_INVALID   = 3'd2;
    localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
    localparam logic [2:0] STAT_BUSY      = 3'd4;

    localparam logic [1:0] REG_ITS_READY    = 2'd0;
    localparam logic [1:0] REG_DOORBELL     = 2'd1;
    localparam logic [1:0] REG_FIRST_VECTOR = 2'd2;

    // Vector arithmetic width: 24-bit vector plus a slot offset, without wrap
    localparam int VEC_EXT_W = 25;

    localparam logic [23:0] FIRST_VECTOR_RST = 24'd8192;

    typedef struct packed {
        logic        used;
        logic        single;
        logic [31:0] owner;
        logic [10:0] evt_num;
    } slot_t;

    typedef struct packed {
        logic        its_ready;
        logic [47:0] doorbell;
        logic [23:0] first_vector;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN_SCAN,
        ST_RUN_FILL,
        ST_REL_SCAN,
        ST_ONE_SCAN,
        ST_SLOT_CHK,
        ST_FINISH
    } state_t;

endpackage

>>> design/msiva_slot_ram.sv
// Slot table memory: one write port, one read port, registered read data.
// Depends on msiva_pkg for the entry layout.
module msiva_slot_ram #(
    parameter int DEPTH = 1024
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  msiva_pkg::slot_t           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output msiva_pkg::slot_t           rdata
);
    import msiva_pkg::*;

    slot_t mem [DEPTH];

    // Write and read; a read of the entry being written returns the old value
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/msiva_seq.sv
// Sequencer: scans, updates and checks the slot table, and holds the result register.
// Depends on msiva_pkg; drives the ports of msiva_slot_ram.
module msiva_seq #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  msiva_pkg::cfg_t                cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     mode,
    input  logic [31:0]                    dev_id,
    input  logic [15:0]                    count,
    input  logic [10:0]                    event_vector,
    input  logic [23:0]                    vector_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [23:0]                    vector_out,
    output logic [47:0]                    msg_addr,
    output logic [10:0]                    msg_data,
    output logic                           ram_we,
    output logic [$clog2(NUM_SLOTS)-1:0]   ram_waddr,
    output msiva_pkg::slot_t               ram_wdata,
    output logic [$clog2(NUM_SLOTS)-1:0]   ram_raddr,
    input  msiva_pkg::slot_t               ram_rdata
);
    import msiva_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] NUM_C  = CNT_W'(NUM_SLOTS);
    localparam logic [IDX_W-1:0] LAST_I = IDX_W'(NUM_SLOTS - 1);

    state_t state_reg, state_next;

    logic [2:0]       mode_reg, mode_next;
    logic [31:0]      dev_reg, dev_next;
    logic [15:0]      count_reg, count_next;
    logic [10:0]      ev_reg, ev_next;
    logic [23:0]      vin_reg, vin_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0] run_len_reg, run_len_next;
    logic [IDX_W-1:0] start_reg, start_next;
    logic             busy_reg, busy_next;
    logic             free_reg, free_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [23:0]      res_vec_reg, res_vec_next;
    logic [47:0]      res_addr_reg, res_addr_next;
    logic [10:0]      res_data_reg, res_data_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg, out_status_next;
    logic [23:0]      out_vec_reg, out_vec_next;
    logic [47:0]      out_addr_reg, out_addr_next;
    logic [10:0]      out_data_reg, out_data_next;

    logic                 in_accept;
    logic                 out_free;
    logic                 cnt_bad;
    logic                 rel_bad;
    logic                 in_tbl;
    logic [IDX_W-1:0]     idx_in;
    logic [VEC_EXT_W-1:0] fv_ext;
    logic [VEC_EXT_W-1:0] vin_ext;
    logic [VEC_EXT_W-1:0] slot_vec;
    logic                 chk_last;
    logic                 clear_last;
    logic [CNT_W-1:0]     run_len_inc;
    logic                 run_hit;
    logic [IDX_W-1:0]     run_start;
    logic                 fill_last;
    logic                 rel_match;
    logic                 one_busy;
    logic                 slot_hit;

    // Shared decode of the request and of the word under check
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid & ~in_stall;
    assign out_free    = ~out_valid_reg | ~out_stall;
    assign fv_ext      = VEC_EXT_W'(cfg.first_vector);
    assign vin_ext     = VEC_EXT_W'(vector_in);
    assign cnt_bad     = (count == 16'd0) || ({1'b0, count} > 17'(NUM_SLOTS));
    assign rel_bad     = (count == 16'd0) || (vector_in < cfg.first_vector);
    assign in_tbl      = (vin_ext >= fv_ext) && (vin_ext < fv_ext + VEC_EXT_W'(NUM_SLOTS));
    assign idx_in      = IDX_W'(vector_in - cfg.first_vector);
    assign chk_last    = pend_reg && (chk_idx_reg == LAST_I);
    assign clear_last  = (rd_cnt_reg[IDX_W-1:0] == LAST_I);
    assign run_len_inc = run_len_reg + 1'b1;
    assign run_hit     = pend_reg && !ram_rdata.used && (run_len_inc == CNT_W'(count_reg));
    assign run_start   = (run_len_reg == '0) ? chk_idx_reg : start_reg;
    assign fill_last   = (fill_reg + 1'b1) == CNT_W'(count_reg);
    assign slot_vec    = fv_ext + VEC_EXT_W'(chk_idx_reg);
    assign rel_match   = pend_reg && (slot_vec >= VEC_EXT_W'(vin_reg))
                         && (slot_vec < VEC_EXT_W'(vin_reg) + VEC_EXT_W'(count_reg))
                         && ram_rdata.used && !ram_rdata.single
                         && (ram_rdata.owner == dev_reg);
    assign one_busy    = pend_reg && ram_rdata.used && (ram_rdata.owner == dev_reg)
                         && (ram_rdata.evt_num == ev_reg);
    assign slot_hit    = ram_rdata.used && ram_rdata.single && (ram_rdata.owner == dev_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_FINISH;
                    case (mode)
                        MODE_ALLOC_RUN:
                        begin
                            if (cfg.its_ready && !cnt_bad)
                            begin
                                state_next = ST_RUN_SCAN;
                            end
                        end
                        MODE_RELEASE_RUN:
                        begin
                            if (!rel_bad)
                            begin
                                state_next = ST_REL_SCAN;
                            end
                        end
                        MODE_ALLOC_ONE:
                        begin
                            if (cfg.its_ready)
                            begin
                                state_next = ST_ONE_SCAN;
                            end
                        end
                        MODE_RELEASE_ONE, MODE_LOOKUP:
                        begin
                            if (in_tbl)
                            begin
                                state_next = ST_SLOT_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_RUN_SCAN:
            begin
                if (run_hit)
                begin
                    state_next = ST_RUN_FILL;
                end
                else if (chk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RUN_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_REL_SCAN, ST_ONE_SCAN:
            begin
                if (chk_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SLOT_CHK:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and result staging
    always_comb
    begin
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        count_next      = count_reg;
        ev_next         = ev_reg;
        vin_next        = vin_reg;
        rd_cnt_next     = rd_cnt_reg;
        pend_next       = pend_reg;
        chk_idx_next    = chk_idx_reg;
        run_len_next    = run_len_reg;
        start_next      = start_reg;
        busy_next       = busy_reg;
        free_next       = free_reg;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_vec_next    = res_vec_reg;
        res_addr_next   = res_addr_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_status_next = out_status_reg;
        out_vec_next    = out_vec_reg;
        out_addr_next   = out_addr_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = chk_idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = (state_reg == ST_IDLE) ? idx_in : rd_cnt_reg[IDX_W-1:0];

        // Scan address issue: one slot read per cycle, each checked in the following cycle
        if (state_reg == ST_RUN_SCAN || state_reg == ST_REL_SCAN || state_reg == ST_ONE_SCAN)
        begin
            pend_next    = (rd_cnt_reg < NUM_C);
            rd_cnt_next  = rd_cnt_reg + CNT_W'(rd_cnt_reg < NUM_C);
            chk_idx_next = rd_cnt_reg[IDX_W-1:0];
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the table clearing used bits
                ram_we         = 1'b1;
                ram_waddr      = rd_cnt_reg[IDX_W-1:0];
                ram_wdata      = '0;
                rd_cnt_next    = rd_cnt_reg + 1'b1;
                out_valid_next = 1'b0;
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next       = mode;
                    dev_next        = dev_id;
                    count_next      = count;
                    ev_next         = event_vector;
                    vin_next        = vector_in;
                    rd_cnt_next     = '0;
                    pend_next       = 1'b0;
                    run_len_next    = '0;
                    busy_next       = 1'b0;
                    free_next       = 1'b0;
                    fill_next       = '0;
                    res_status_next = STAT_OK;
                    res_vec_next    = '0;
                    res_addr_next   = '0;
                    res_data_next   = '0;
                    case (mode)
                        MODE_ALLOC_RUN:
                        begin
                            if (!cfg.its_ready)
                            begin
                                res_status_next = STAT_NOT_READY;
                            end
                            else if (cnt_bad)
                            begin
                                res_status_next = STAT_INVALID;
                            end
                        end
                        MODE_RELEASE_RUN:
                        begin
                            if (rel_bad)
                            begin
                                res_status_next = STAT_INVALID;
                            end
                        end
                        MODE_ALLOC_ONE:
                        begin
                            if (!cfg.its_ready)
                            begin
                                res_status_next = STAT_NOT_READY;
                            end
                        end
                        MODE_RELEASE_ONE:
                        begin
                            res_status_next = STAT_OK;
                        end
                        MODE_LOOKUP:
                        begin
                            if (!in_tbl)
                            begin
                                res_status_next = STAT_INVALID;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_RUN_SCAN:
            begin
                // Track the current stretch of free slots
                if (pend_reg)
                begin
                    if (ram_rdata.used)
                    begin
                        run_len_next = '0;
                    end
                    else
                    begin
                        run_len_next = run_len_inc;
                        start_next   = run_start;
                    end
                end
                if (!run_hit && chk_last)
                begin
                    res_status_next = STAT_NO_SPACE;
                end
            end
            ST_RUN_FILL:
            begin
                // Claim the run, numbering events from zero
                ram_we            = 1'b1;
                ram_waddr         = start_reg + IDX_W'(fill_reg);
                ram_wdata.used    = 1'b1;
                ram_wdata.single  = 1'b0;
                ram_wdata.owner   = dev_reg;
                ram_wdata.evt_num = 11'(fill_reg);
                fill_next         = fill_reg + 1'b1;
                if (fill_last)
                begin
                    res_status_next = STAT_OK;
                    res_vec_next    = cfg.first_vector + 24'(start_reg);
                    res_addr_next   = cfg.doorbell;
                    res_data_next   = '0;
                end
            end
            ST_REL_SCAN:
            begin
                // Free matching run slots in place
                if (rel_match)
                begin
                    ram_we         = 1'b1;
                    ram_wdata.used = 1'b0;
                end
            end
            ST_ONE_SCAN:
            begin
                // Look for a duplicate event and the lowest free slot
                if (one_busy)
                begin
                    busy_next = 1'b1;
                end
                if (pend_reg && !ram_rdata.used && !free_reg)
                begin
                    free_next  = 1'b1;
                    start_next = chk_idx_reg;
                end
                if (chk_last)
                begin
                    if (busy_reg || one_busy)
                    begin
                        res_status_next = STAT_BUSY;
                    end
                    else if (!free_reg && ram_rdata.used)
                    begin
                        res_status_next = STAT_NO_SPACE;
                    end
                    else
                    begin
                        ram_we            = 1'b1;
                        ram_waddr         = free_reg ? start_reg : chk_idx_reg;
                        ram_wdata.used    = 1'b1;
                        ram_wdata.single  = 1'b1;
                        ram_wdata.owner   = dev_reg;
                        ram_wdata.evt_num = ev_reg;
                        res_status_next   = STAT_OK;
                        res_vec_next      = cfg.first_vector
                                            + 24'(free_reg ? start_reg : chk_idx_reg);
                        res_addr_next     = cfg.doorbell;
                        res_data_next     = ev_reg;
                    end
                end
            end
            ST_SLOT_CHK:
            begin
                ram_waddr = IDX_W'(vin_reg - cfg.first_vector);
                if (mode_reg == MODE_RELEASE_ONE)
                begin
                    if (slot_hit)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.used = 1'b0;
                    end
                end
                else if (!ram_rdata.used)
                begin
                    res_status_next = STAT_INVALID;
                end
                else if (!cfg.its_ready)
                begin
                    res_status_next = STAT_NOT_READY;
                end
                else
                begin
                    res_vec_next  = vin_reg;
                    res_addr_next = cfg.doorbell;
                    res_data_next = ram_rdata.evt_num;
                end
            end
            ST_FINISH:
            begin
                // Hand the item to the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_vec_next    = res_vec_reg;
                    out_addr_next   = res_addr_reg;
                    out_data_next   = res_data_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rd_cnt_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        dev_reg        <= dev_next;
        count_reg      <= count_next;
        ev_reg         <= ev_next;
        vin_reg        <= vin_next;
        chk_idx_reg    <= chk_idx_next;
        run_len_reg    <= run_len_next;
        start_reg      <= start_next;
        busy_reg       <= busy_next;
        free_reg       <= free_next;
        fill_reg       <= fill_next;
        res_status_reg <= res_status_next;
        res_vec_reg    <= res_vec_next;
        res_addr_reg   <= res_addr_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_vec_reg    <= out_vec_next;
        out_addr_reg   <= out_addr_next;
        out_data_reg   <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign vector_out = out_vec_reg;
    assign msg_addr   = out_addr_reg;
    assign msg_data   = out_data_reg;

endmodule

>>> design/msi_vector_slot_allocator_unit.sv
// One item is taken at a time; run allocate, run release and single allocate scan the
// slot table memory one slot per cycle.
// After reset the table's used bits are cleared, and no item is taken until that sweep
// is done; config writes are taken at all times.
// Top level: config registers, sequencer and slot table memory. Depends on msiva_pkg.
module msi_vector_slot_allocator_unit #(
    parameter int NUM_SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [31:0] dev_id,
    input  logic [15:0] count,
    input  logic [10:0] event_vector,
    input  logic [23:0] vector_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [23:0] vector_out,
    output logic [47:0] msg_addr,
    output logic [10:0] msg_data
);
    import msiva_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    cfg_t             cfg_reg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    slot_t            ram_wdata;
    slot_t            ram_rdata;

    assign cfg_ready = 1'b1;

    // Config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.its_ready    <= 1'b0;
            cfg_reg.doorbell     <= '0;
            cfg_reg.first_vector <= FIRST_VECTOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ITS_READY:    cfg_reg.its_ready    <= cfg_data[0];
                REG_DOORBELL:     cfg_reg.doorbell     <= cfg_data;
                REG_FIRST_VECTOR: cfg_reg.first_vector <= cfg_data[23:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    msiva_seq #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .dev_id       (dev_id),
        .count        (count),
        .event_vector (event_vector),
        .vector_in    (vector_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .vector_out   (vector_out),
        .msg_addr     (msg_addr),
        .msg_data     (msg_data),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    msiva_slot_ram #(
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
